### src/int_vec3_alu_top_defines.svh
// assertion macros shared by the vector unit
`ifndef INT_VEC3_ALU_TOP_DEFINES_SVH
`define INT_VEC3_ALU_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IVEC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ivec3 check failed");

// next-cycle implication, checked out of reset
`define IVEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ivec3 check failed");

`endif

### src/ivec3_pkg.sv
package ivec3_pkg;

    localparam int W = 32;
    localparam int ACT_W = 4;

    // action codes
    localparam logic [ACT_W-1:0] ACT_VADD   = 4'd0;
    localparam logic [ACT_W-1:0] ACT_VSUB   = 4'd1;
    localparam logic [ACT_W-1:0] ACT_VMUL   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_VDIV   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_SADD   = 4'd4;
    localparam logic [ACT_W-1:0] ACT_SSUB   = 4'd5;
    localparam logic [ACT_W-1:0] ACT_SMUL   = 4'd6;
    localparam logic [ACT_W-1:0] ACT_SDIV   = 4'd7;
    localparam logic [ACT_W-1:0] ACT_DOT    = 4'd8;
    localparam logic [ACT_W-1:0] ACT_CROSS  = 4'd9;
    localparam logic [ACT_W-1:0] ACT_EQUAL  = 4'd10;
    localparam logic [ACT_W-1:0] ACT_ROTL   = 4'd11;
    localparam logic [ACT_W-1:0] ACT_ROTR   = 4'd12;
    localparam logic [ACT_W-1:0] ACT_DIGITS = 4'd13;

    // divisors used to split a number into digits
    localparam logic [W-1:0] DIV_THOUSAND = W'(1000);
    localparam logic [W-1:0] DIV_HUNDRED  = W'(100);
    localparam logic [W-1:0] DIV_TEN      = W'(10);

    // state carried down the pipeline, three lanes
    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [2:0]        neg;
        logic [2:0]        dz;
        logic [2:0][W-1:0] rem;
        logic [2:0][W-1:0] qd;
        logic [2:0][W-1:0] dv;
        logic [2:0][W-1:0] res;
        logic [W-1:0]      sc;
        logic              eq;
    } pipe_t;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    // one restoring division step: returns {rem, dividend/quotient}
    function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rem,
                                                input logic [W-1:0] qd,
                                                input logic [W-1:0] dv);
        logic [W:0] t;
        logic [W:0] d;
        t = {rem, qd[W-1]};
        d = t - {1'b0, dv};
        if (!d[W])
            return {d[W-1:0], qd[W-2:0], 1'b1};
        else
            return {t[W-1:0], qd[W-2:0], 1'b0};
    endfunction

    // quotient of a value below ten units by that unit
    function automatic logic [3:0] small_quot(input logic [9:0] v, input logic [6:0] unit);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if ({4'd0, v} >= 14'(k) * {7'd0, unit})
                q = 4'(k);
        end
        return q;
    endfunction

endpackage

### src/ivec3_in_if.sv
interface ivec3_in_if;
    logic                                valid;
    logic                                ready;
    logic [ivec3_pkg::ACT_W-1:0]         action;
    logic signed [ivec3_pkg::W-1:0]      ax;
    logic signed [ivec3_pkg::W-1:0]      ay;
    logic signed [ivec3_pkg::W-1:0]      az;
    logic signed [ivec3_pkg::W-1:0]      bx;
    logic signed [ivec3_pkg::W-1:0]      by;
    logic signed [ivec3_pkg::W-1:0]      bz;
    logic signed [ivec3_pkg::W-1:0]      scalar_in;

    modport source (output valid, action, ax, ay, az, bx, by, bz, scalar_in, input ready);
    modport sink (input valid, action, ax, ay, az, bx, by, bz, scalar_in, output ready);
endinterface

### src/ivec3_out_if.sv
interface ivec3_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [ivec3_pkg::W-1:0] rx;
    logic signed [ivec3_pkg::W-1:0] ry;
    logic signed [ivec3_pkg::W-1:0] rz;
    logic signed [ivec3_pkg::W-1:0] scalar_out;
    logic                           equal;
    logic                           div_zero;

    modport source (output valid, rx, ry, rz, scalar_out, equal, div_zero, input ready);
    modport sink (input valid, rx, ry, rz, scalar_out, equal, div_zero, output ready);
endinterface

### src/int_vec3_alu_top.sv
// three-component signed integer vector unit
// req channel: action code, vectors a and b, scalar_in; rsp channel: vector
// rx/ry/rz, scalar_out (dot product), equal and div_zero flags
// one result per transfer, no configuration, no state between items
// each item passes stage 0, the divider stages and the output register, the
// same for every action; throughput one item per cycle while rsp is not stalled
// the depth is set by the divider: 32 restoring steps, one quotient bit per
// stage, in three lanes; the six multipliers sit in the first stage and the
// adds that follow them in the second
// a valid bit travels with each stage; when rsp is stalled the whole
// pipeline holds and req.ready drops, so nothing is lost or repeated
// reset clears the valid bits only; after reset the unit is empty and ready
// zero divisors give zero in that component and raise div_zero
`include "int_vec3_alu_top_defines.svh"

module int_vec3_alu_top (
    input  logic         clk,
    input  logic         rst_n,
    ivec3_in_if.sink     req,
    ivec3_out_if.source  rsp
);

    localparam int W = ivec3_pkg::W;

    logic                  adv;
    logic [W:0]            vld_reg;
    ivec3_pkg::pipe_t      stg_reg  [0:W];
    ivec3_pkg::pipe_t      s0_next;
    ivec3_pkg::pipe_t      stg_next [1:W];
    logic [5:0][W-1:0]     prod_reg;
    logic [5:0][W-1:0]     prod_next;
    logic [2:0][W-1:0]     av;
    logic [2:0][W-1:0]     bv;
    logic [W-1:0]          sv;

    logic                  out_vld_reg;
    logic [ivec3_pkg::ACT_W-1:0] out_act_reg;
    logic [2:0][W-1:0]     r_reg;
    logic [2:0][W-1:0]     r_next;
    logic [W-1:0]          sc_reg;
    logic                  eq_reg;
    logic                  dz_reg;

    // pipeline moves whenever the output slot is free or being taken
    assign adv = !out_vld_reg || rsp.ready;
    assign req.ready = adv;

    assign av[0] = req.ax;
    assign av[1] = req.ay;
    assign av[2] = req.az;
    assign bv[0] = req.bx;
    assign bv[1] = req.by;
    assign bv[2] = req.bz;
    assign sv    = req.scalar_in;

    // stage 0: operand setup, short ops, divider load
    always_comb
    begin
        s0_next = '0;
        s0_next.act = req.action;
        for (int i = 0; i < 3; i++)
        begin
            case (req.action)
                ivec3_pkg::ACT_VADD: s0_next.res[i] = av[i] + bv[i];
                ivec3_pkg::ACT_VSUB: s0_next.res[i] = av[i] - bv[i];
                ivec3_pkg::ACT_SADD: s0_next.res[i] = av[i] + sv;
                ivec3_pkg::ACT_SSUB: s0_next.res[i] = av[i] - sv;
                ivec3_pkg::ACT_ROTL: s0_next.res[i] = av[(i + 1) % 3];
                ivec3_pkg::ACT_ROTR: s0_next.res[i] = av[(i + 2) % 3];
                ivec3_pkg::ACT_VDIV:
                begin
                    s0_next.qd[i]  = ivec3_pkg::mag(av[i]);
                    s0_next.dv[i]  = ivec3_pkg::mag(bv[i]);
                    s0_next.neg[i] = av[i][W-1] ^ bv[i][W-1];
                    s0_next.dz[i]  = (bv[i] == '0);
                end
                ivec3_pkg::ACT_SDIV:
                begin
                    s0_next.qd[i]  = ivec3_pkg::mag(av[i]);
                    s0_next.dv[i]  = ivec3_pkg::mag(sv);
                    s0_next.neg[i] = av[i][W-1] ^ sv[W-1];
                    s0_next.dz[i]  = (sv == '0);
                end
                ivec3_pkg::ACT_DIGITS:
                begin
                    s0_next.qd[i]  = ivec3_pkg::mag(sv);
                    s0_next.neg[i] = sv[W-1];
                end
                default: s0_next.res[i] = '0;
            endcase
        end
        // digit lanes: remainders by 1000, 100 and 10
        if (req.action == ivec3_pkg::ACT_DIGITS)
        begin
            s0_next.dv[0] = ivec3_pkg::DIV_THOUSAND;
            s0_next.dv[1] = ivec3_pkg::DIV_HUNDRED;
            s0_next.dv[2] = ivec3_pkg::DIV_TEN;
        end
        s0_next.eq = (req.action == ivec3_pkg::ACT_EQUAL) && (av == bv);
    end

    // stage 0 multipliers, six lanes, low word kept
    always_comb
    begin
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        logic [2*W-1:0] full;
        for (int i = 0; i < 3; i++)
        begin
            ma = av[i];
            mb = bv[i];
            if (req.action == ivec3_pkg::ACT_SMUL)
                mb = sv;
            else if (req.action == ivec3_pkg::ACT_CROSS)
            begin
                ma = av[(i + 1) % 3];
                mb = bv[(i + 2) % 3];
            end
            full = ma * mb;
            prod_next[i] = full[W-1:0];
            full = av[(i + 2) % 3] * bv[(i + 1) % 3];
            prod_next[i + 3] = full[W-1:0];
        end
    end

    // divider stages; stage 1 also folds in the products
    always_comb
    begin
        for (int k = 1; k <= W; k++)
        begin
            stg_next[k] = stg_reg[k-1];
            for (int i = 0; i < 3; i++)
                {stg_next[k].rem[i], stg_next[k].qd[i]} =
                    ivec3_pkg::div_step(stg_reg[k-1].rem[i], stg_reg[k-1].qd[i],
                                        stg_reg[k-1].dv[i]);
        end
        case (stg_reg[0].act)
            ivec3_pkg::ACT_VMUL, ivec3_pkg::ACT_SMUL:
                for (int i = 0; i < 3; i++)
                    stg_next[1].res[i] = prod_reg[i];
            ivec3_pkg::ACT_DOT:
                stg_next[1].sc = prod_reg[0] + prod_reg[1] + prod_reg[2];
            ivec3_pkg::ACT_CROSS:
                for (int i = 0; i < 3; i++)
                    stg_next[1].res[i] = prod_reg[i] - prod_reg[i + 3];
            default: stg_next[1].sc = '0;
        endcase
    end

    // final stage: signs, zero divisors, digit extraction
    always_comb
    begin
        ivec3_pkg::pipe_t  p;
        logic [2:0][W-1:0] dig;
        p = stg_reg[W];
        dig[0] = {{(W-4){1'b0}}, ivec3_pkg::small_quot(p.rem[0][9:0], 7'd100)};
        dig[1] = {{(W-4){1'b0}}, ivec3_pkg::small_quot(p.rem[1][9:0], 7'd10)};
        dig[2] = p.rem[2];
        for (int i = 0; i < 3; i++)
        begin
            case (p.act)
                ivec3_pkg::ACT_VDIV, ivec3_pkg::ACT_SDIV:
                    r_next[i] = p.dz[i] ? '0 : (p.neg[i] ? (~p.qd[i] + W'(1)) : p.qd[i]);
                ivec3_pkg::ACT_DIGITS:
                    r_next[i] = p.neg[i] ? (~dig[i] + W'(1)) : dig[i];
                default:
                    r_next[i] = p.res[i];
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[W-1:0], req.valid};
            out_vld_reg <= vld_reg[W];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            stg_reg[0] <= s0_next;
            for (int k = 1; k <= W; k++)
                stg_reg[k] <= stg_next[k];
            r_reg       <= r_next;
            sc_reg      <= stg_reg[W].sc;
            eq_reg      <= stg_reg[W].eq;
            dz_reg      <= |stg_reg[W].dz;
            out_act_reg <= stg_reg[W].act;
        end
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.rx         = r_reg[0];
    assign rsp.ry         = r_reg[1];
    assign rsp.rz         = r_reg[2];
    assign rsp.scalar_out = sc_reg;
    assign rsp.equal      = eq_reg;
    assign rsp.div_zero   = dz_reg;

    // checks
    `IVEC_ASSERT_NOW(a_dz_only_div, out_vld_reg && dz_reg,
        out_act_reg == ivec3_pkg::ACT_VDIV || out_act_reg == ivec3_pkg::ACT_SDIV)
    `IVEC_ASSERT_NOW(a_eq_quiet, out_vld_reg && eq_reg,
        r_reg == '0 && sc_reg == '0 && out_act_reg == ivec3_pkg::ACT_EQUAL)
    `IVEC_ASSERT_NOW(a_ready_when_empty, !out_vld_reg, req.ready)
    `IVEC_ASSERT_NEXT(a_tail_holds, vld_reg[W] && !adv, vld_reg[W])

endmodule
